@@ hdl/lwebed_pkg.sv @@
// ---------------------------------------------------------------------------
// LWE bit encryption and decryption: shared constants and types
// Modulus, key length, Barrett reduction constants and the result record.
// ---------------------------------------------------------------------------
package lwebed_pkg;

	localparam int KEY_LEN   = 16;
	localparam int KEY_AW    = $clog2(KEY_LEN);
	localparam int MODULUS   = 3329;
	localparam int Q_W       = 12;
	localparam int PROD_W    = 2 * Q_W;
	localparam int BARRETT_K = PROD_W;
	localparam int BARRETT_M = (1 << BARRETT_K) / MODULUS;
	localparam int BM_W      = $clog2(BARRETT_M + 1);
	localparam int QH_W      = PROD_W - BARRETT_K + BM_W;
	localparam int SUM_W     = Q_W + 2;
	localparam int HALF_Q    = MODULUS / 2;
	localparam int QUARTER_Q = MODULUS / 4;

	localparam logic [Q_W-1:0] MOD_Q      = Q_W'(MODULUS);
	localparam logic [Q_W-1:0] HALF_Q1    = Q_W'(HALF_Q + 1);
	localparam logic [Q_W-1:0] QUARTER_QV = Q_W'(QUARTER_Q);
	localparam logic [Q_W-1:0] UPPER_QV   = Q_W'(MODULUS - QUARTER_Q);
	localparam logic [BM_W-1:0] BARRETT_MV = BM_W'(BARRETT_M);

	typedef enum logic {
		FUNC_KEY = 1'b0,
		FUNC_ROW = 1'b1
	} func_t;

	typedef struct packed {
		logic           plain_bit;
		logic [Q_W-1:0] cipher_out;
	} res_t;

	function automatic logic [Q_W-1:0] reduce_q(input logic [Q_W-1:0] v);
		reduce_q = (v >= MOD_Q) ? v - MOD_Q : v;
	endfunction

endpackage

@@ hdl/lwe_bit_encrypt_decrypt_top.sv @@
// ---------------------------------------------------------------------------
// LWE bit encryption and decryption
// Keeps a secret key, accumulates the inner product of a streamed matrix row
// with the key modulo Q, and closes each row with an encrypted value or a
// decrypted bit.
// ---------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tuser func, tlast row_last, tdata element and operands
// m_axis    out        tdata cipher_out and plain_bit, one per closed row
// cfg       in         decrypt_mode, written when cfg_we is high
//
// One item is taken every cycle while input ready is high. A row's result is
// presented after its last element passes five pipeline stages (key read, multiply,
// Barrett quotient, Barrett correction, modular accumulate), the first loaded as the
// element is taken, then the output register.
// Reset clears the valid bits, the accumulator, the element position and the
// mode; key entries hold nothing until written.
// A two-entry output buffer lets the input run on while one result waits;
// input ready drops only when both entries are full.
// ---------------------------------------------------------------------------
module lwe_bit_encrypt_decrypt_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] key_index, [15:4] elem_value, [16] message_bit,
	// [28:17] cipher_in, [30:29] noise, [31] zero
	input  logic [31:0] s_axis_tdata,
	// [0] func
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [11:0] cipher_out, [12] plain_bit, [15:13] zero
	output logic [15:0] m_axis_tdata
);
	import lwebed_pkg::*;

	logic             decrypt_mode_q;
	logic [Q_W-1:0]   key_store_q [KEY_LEN];
	logic [KEY_AW-1:0] elem_pos_q;
	logic [Q_W-1:0]   acc_q;

	logic             en;
	logic             in_acc;
	logic [KEY_AW-1:0] in_kidx;
	logic [Q_W-1:0]   in_elem;
	logic             in_msg;
	logic [Q_W-1:0]   in_cin;
	logic [1:0]       in_noise;

	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic             last_s1, last_s2, last_s3, last_s4;
	logic             msg_s1, msg_s2, msg_s3, msg_s4, msg_s5;
	logic [Q_W-1:0]   cin_s1, cin_s2, cin_s3, cin_s4, cin_s5;
	logic [1:0]       noise_s1, noise_s2, noise_s3, noise_s4, noise_s5;
	logic [Q_W-1:0]   key_s1, elem_s1;
	logic [PROD_W-1:0] prod_s2, prod_s3;
	logic [QH_W-1:0]  qhat_s3;
	logic [Q_W-1:0]   pmod_s4;
	logic [Q_W-1:0]   acc_s5;

	logic [PROD_W+BM_W-1:0] qhat_full;
	logic [PROD_W-1:0] rem_wide;
	logic [Q_W:0]     acc_sum;
	logic [Q_W-1:0]   acc_next;

	logic signed [SUM_W-1:0] enc_u;
	logic [Q_W-1:0]   enc_val;
	logic signed [SUM_W-1:0] dec_d;
	logic [Q_W-1:0]   dec_dm;
	res_t             res_new;

	logic             out_valid_q, skid_valid_q;
	res_t             out_q, skid_q;
	logic             new_valid, pop;

	assign en       = !(out_valid_q && skid_valid_q);
	assign in_acc   = s_axis_tvalid && en;
	assign in_kidx  = s_axis_tdata[3:0];
	assign in_elem  = s_axis_tdata[15:4];
	assign in_msg   = s_axis_tdata[16];
	assign in_cin   = s_axis_tdata[28:17];
	assign in_noise = s_axis_tdata[30:29];

	assign s_axis_tready = en;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_mode_q <= 1'b0;
		end else if (cfg_we) begin
			decrypt_mode_q <= cfg_wdata;
		end
	end

	// Key store
	always_ff @(posedge clk) begin
		if (in_acc && (func_t'(s_axis_tuser) == FUNC_KEY)) begin
			key_store_q[in_kidx] <= in_elem;
		end
	end

	// Row position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_pos_q <= '0;
		end else if (in_acc && (func_t'(s_axis_tuser) == FUNC_ROW)) begin
			if (s_axis_tlast || (elem_pos_q == KEY_AW'(KEY_LEN - 1))) begin
				elem_pos_q <= '0;
			end else begin
				elem_pos_q <= elem_pos_q + 1'b1;
			end
		end
	end

	assign qhat_full = prod_s2 * BARRETT_MV;
	assign rem_wide  = prod_s3 - PROD_W'(qhat_s3) * PROD_W'(MODULUS);
	assign acc_sum   = {1'b0, acc_q} + {1'b0, pmod_s4};
	assign acc_next  = (acc_sum >= {1'b0, MOD_Q}) ? Q_W'(acc_sum - {1'b0, MOD_Q})
	                                              : acc_sum[Q_W-1:0];

	// Pipeline valid bits and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			acc_q    <= '0;
		end else if (en) begin
			valid_s1 <= in_acc && (func_t'(s_axis_tuser) == FUNC_ROW);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4 && last_s4;
			if (valid_s4) begin
				acc_q <= last_s4 ? '0 : acc_next;
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			key_s1   <= reduce_q(key_store_q[elem_pos_q]);
			elem_s1  <= reduce_q(in_elem);
			last_s1  <= s_axis_tlast;
			msg_s1   <= in_msg;
			cin_s1   <= reduce_q(in_cin);
			noise_s1 <= in_noise;

			prod_s2  <= PROD_W'(key_s1) * PROD_W'(elem_s1);
			last_s2  <= last_s1;
			msg_s2   <= msg_s1;
			cin_s2   <= cin_s1;
			noise_s2 <= noise_s1;

			prod_s3  <= prod_s2;
			qhat_s3  <= qhat_full[PROD_W+BM_W-1:BARRETT_K];
			last_s3  <= last_s2;
			msg_s3   <= msg_s2;
			cin_s3   <= cin_s2;
			noise_s3 <= noise_s2;

			pmod_s4  <= (rem_wide >= PROD_W'(MODULUS)) ? Q_W'(rem_wide - PROD_W'(MODULUS))
			                                           : rem_wide[Q_W-1:0];
			last_s4  <= last_s3;
			msg_s4   <= msg_s3;
			cin_s4   <= cin_s3;
			noise_s4 <= noise_s3;

			acc_s5   <= acc_next;
			msg_s5   <= msg_s4;
			cin_s5   <= cin_s4;
			noise_s5 <= noise_s4;
		end
	end

	// Result from the closed row
	always_comb begin
		enc_u = $signed({2'b00, acc_s5})
		      + $signed({2'b00, (msg_s5 ? HALF_Q1 : {Q_W{1'b0}})})
		      + $signed({{(SUM_W-2){noise_s5[1]}}, noise_s5});
		if (enc_u < 0) begin
			enc_val = Q_W'(enc_u + $signed({2'b00, MOD_Q}));
		end else if (enc_u >= $signed({2'b00, MOD_Q})) begin
			enc_val = Q_W'(enc_u - $signed({2'b00, MOD_Q}));
		end else begin
			enc_val = enc_u[Q_W-1:0];
		end

		dec_d = $signed({2'b00, cin_s5}) - $signed({2'b00, acc_s5});
		if (dec_d < 0) begin
			dec_dm = Q_W'(dec_d + $signed({2'b00, MOD_Q}));
		end else begin
			dec_dm = dec_d[Q_W-1:0];
		end

		if (decrypt_mode_q) begin
			res_new.cipher_out = '0;
			res_new.plain_bit  = (dec_dm >= QUARTER_QV) && (dec_dm <= UPPER_QV);
		end else begin
			res_new.cipher_out = enc_val;
			res_new.plain_bit  = 1'b0;
		end
	end

	assign new_valid = en && valid_s5;
	assign pop       = out_valid_q && m_axis_tready;

	// Output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || new_valid;
			skid_valid_q <= skid_valid_q && new_valid;
		end else if (new_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end else if (new_valid) begin
			skid_q <= res_new;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.plain_bit, out_q.cipher_out};

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q < MOD_Q)
		else $error("accumulator left the residue range");

	a_pos_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (func_t'(s_axis_tuser) == FUNC_ROW) && s_axis_tlast)
		|=> (elem_pos_q == '0 && valid_s1))
		else $error("row position not cleared after the last element");

	a_row_close: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s4 && last_s4) |=> (acc_q == '0 && valid_s5))
		else $error("closing row did not clear the accumulator");

	a_cipher_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.cipher_out < MOD_Q))
		else $error("ciphertext value out of range");
`endif

endmodule
